/* design/uba_pkg.sv */
// Shared types and constants for the uniform block allocator.
package uba_pkg;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 224;
    localparam int ENTRY_W    = 112;

    localparam logic [31:0] SEG_BYTES_RST = 32'd67108864;
    localparam logic [31:0] BLK_BYTES_RST = 32'd65536;
    localparam logic [10:0] LOW_WATER_RST = 11'd16;

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_ALLOC = 2'd1,
        FN_FREE  = 2'd2,
        FN_QUERY = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_TOO_BIG = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_SEG_BYTES = 2'd0,
        CFG_BLK_BYTES = 2'd1,
        CFG_LOW_WATER = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_ROOM,
        MUL_SEG,
        MUL_USED,
        MUL_SUM
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ADD_MUL,
        S_ADD_CHK,
        S_PUSH,
        S_ALLOC,
        S_ALLOC_CAP,
        S_FREE,
        S_M1,
        S_M2,
        S_M3,
        S_FIN
    } state_t;

    typedef struct packed {
        logic     take_in;
        logic     scan_rd;
        logic     scan_cmp;
        logic     add_commit;
        logic     push;
        logic     alloc_pop;
        logic     alloc_cap;
        logic     free_push;
        logic     ld_lim;
        logic     ld_tot;
        logic     ld_ub;
        logic     ld_sb;
        logic     load_out;
        logic     set_status;
        status_t  code;
        mul_sel_t mul_sel;
    } cmd_t;

    typedef struct packed {
        logic segc_zero;
        logic scan_last;
        logic dup;
        logic seg_full;
        logic room_short;
        logic push_more;
        logic size_big;
        logic fifo_empty;
        logic fifo_full;
        logic out_free;
    } sts_t;

endpackage

/* design/uniform_block_allocator_unit.sv */
// Top level of the uniform block allocator: controller plus datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tuser func, tdata request fields
//  m_axis    out        m_axis_tvalid/m_axis_tready    tuser status, tdata block and counters
//  cfg       in         cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Query runs S_M1, S_M2, S_M3 and S_FIN. Free adds S_FREE; allocate adds S_ALLOC and, unless rejected,
// S_ALLOC_CAP (free-list RAM read). Add segment adds a duplicate scan over the segment RAM, then S_ADD_MUL,
// S_ADD_CHK and S_PUSH for the blocks pushed (one free-list write per cycle); a rejected add skips S_PUSH.
// Results sit in an output register; the next item is taken once the FSM is back in idle.
// A stalled m_axis holds the FSM in its final state. Reset needs no clearing pass.
module uniform_block_allocator_unit import uba_pkg::*; #(
    parameter int FREE_DEPTH = 1024,
    parameter int SEG_DEPTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // base_addr[63:0], access_key[95:64], server_id[111:96], req_size[143:112]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // blk_addr[63:0], blk_key[95:64], blk_server[111:96], blk_size[143:112],
    // free_bytes[207:144], free_count[218:208], below_water[219], consistent[220]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]            m_axis_tuser
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    uba_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    uba_dp #(
        .FREE_DEPTH (FREE_DEPTH),
        .SEG_DEPTH  (SEG_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

/* design/uba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/uba_ctrl.sv */
// Controller state machine for the uniform block allocator.
module uba_ctrl import uba_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic [1:0] s_axis_tuser,
    output logic       s_axis_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    func_t  in_func;

    assign in_func = func_t'(s_axis_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (in_func)
                        FN_ADD:   state_next = sts.segc_zero ? S_ADD_MUL : S_SCAN_RD;
                        FN_ALLOC: state_next = S_ALLOC;
                        FN_FREE:  state_next = S_FREE;
                        FN_QUERY: state_next = S_M1;
                        default:  state_next = S_M1;
                    endcase
                end
            end
            S_SCAN_RD:   state_next = S_SCAN_CMP;
            S_SCAN_CMP:  state_next = sts.scan_last ? S_ADD_MUL : S_SCAN_RD;
            S_ADD_MUL:   state_next = S_ADD_CHK;
            S_ADD_CHK:
            begin
                priority if (sts.dup || sts.seg_full || sts.room_short)
                begin
                    state_next = S_M1;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:      state_next = sts.push_more ? S_PUSH : S_M1;
            S_ALLOC:
            begin
                priority if (sts.size_big || sts.fifo_empty)
                begin
                    state_next = S_M1;
                end
                else
                begin
                    state_next = S_ALLOC_CAP;
                end
            end
            S_ALLOC_CAP: state_next = S_M1;
            S_FREE:      state_next = S_M1;
            S_M1:        state_next = S_M2;
            S_M2:        state_next = S_M3;
            S_M3:        state_next = S_FIN;
            S_FIN:       state_next = sts.out_free ? S_IDLE : S_FIN;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.code      = ST_OK;
        cmd.mul_sel   = MUL_SEG;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.take_in   = s_axis_tvalid;
            end
            S_SCAN_RD:  cmd.scan_rd = 1'b1;
            S_SCAN_CMP: cmd.scan_cmp = 1'b1;
            S_ADD_MUL:
            begin
                cmd.mul_sel = MUL_ROOM;
                cmd.ld_lim  = 1'b1;
            end
            S_ADD_CHK:
            begin
                priority if (sts.dup)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_DUP;
                end
                else if (sts.seg_full || sts.room_short)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_FULL;
                end
                else
                begin
                    cmd.add_commit = 1'b1;
                end
            end
            S_PUSH: cmd.push = sts.push_more;
            S_ALLOC:
            begin
                priority if (sts.size_big)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_TOO_BIG;
                end
                else if (sts.fifo_empty)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_EMPTY;
                end
                else
                begin
                    cmd.alloc_pop = 1'b1;
                end
            end
            S_ALLOC_CAP: cmd.alloc_cap = 1'b1;
            S_FREE:
            begin
                if (sts.fifo_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_FULL;
                end
                else
                begin
                    cmd.free_push = 1'b1;
                end
            end
            S_M1:
            begin
                cmd.mul_sel = MUL_SEG;
                cmd.ld_tot  = 1'b1;
            end
            S_M2:
            begin
                cmd.mul_sel = MUL_USED;
                cmd.ld_ub   = 1'b1;
            end
            S_M3:
            begin
                cmd.mul_sel = MUL_SUM;
                cmd.ld_sb   = 1'b1;
            end
            S_FIN:   cmd.load_out = sts.out_free;
            default: cmd.take_in = 1'b0;
        endcase
    end

endmodule

/* design/uba_dp.sv */
// Datapath: config registers, free list, segment table, counters and result register.
module uba_dp import uba_pkg::*; #(
    parameter int FREE_DEPTH = 1024,
    parameter int SEG_DEPTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]            m_axis_tuser,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int CW  = $clog2(FREE_DEPTH + 1);
    localparam int PW  = $clog2(FREE_DEPTH);
    localparam int SCW = $clog2(SEG_DEPTH + 1);
    localparam int SIW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    // used count stays at or below (SEG_DEPTH + 1) * FREE_DEPTH: used plus free only
    // grows by a whole segment or by a free with nothing in use
    localparam int UW  = $clog2((SEG_DEPTH + 1) * FREE_DEPTH + 1);
    localparam int SW  = UW + 1;
    localparam int MAW = (SW > SCW) ? SW : SCW;
    localparam int PRW = MAW + 32;

    localparam logic [CW-1:0]  FD_C      = CW'(FREE_DEPTH);
    localparam logic [PW-1:0]  LAST_PTR  = PW'(FREE_DEPTH - 1);
    localparam logic [SCW-1:0] SD_C      = SCW'(SEG_DEPTH);

    // input item
    func_t        in_func_reg;
    logic [63:0]  in_addr_reg;
    logic [31:0]  in_key_reg;
    logic [15:0]  in_srv_reg;
    logic [31:0]  in_req_reg;

    // configuration
    logic [31:0]  seg_bytes_reg;
    logic [31:0]  blk_bytes_reg;
    logic [10:0]  low_water_reg;

    // allocator state
    logic [PW-1:0]  head_reg;
    logic [PW-1:0]  tail_reg;
    logic [CW-1:0]  cnt_reg;
    logic [UW-1:0]  used_reg;
    logic [SCW-1:0] segc_reg;

    // per-item work
    logic [SIW-1:0] scan_reg;
    logic           dup_reg;
    status_t        stat_reg;
    logic [63:0]    blk_addr_reg;
    logic [31:0]    blk_key_reg;
    logic [15:0]    blk_srv_reg;
    logic [31:0]    blk_size_reg;
    logic [63:0]    cur_addr_reg;
    logic [31:0]    rem_reg;
    logic [PRW-1:0] lim_reg;
    logic [PRW-1:0] tot_reg;
    logic [PRW-1:0] ub_reg;
    logic [PRW-1:0] sb_reg;
    logic [63:0]    fb_reg;

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    status_t               out_stat_reg;

    logic [PW-1:0]      head_next;
    logic [PW-1:0]      tail_next;
    logic [MAW-1:0]     mul_a;
    logic [31:0]        mul_b;
    logic [PRW-1:0]     mul_p;
    logic [SW-1:0]      sum_cnt;
    logic               consistent;
    logic               below_water;
    logic               blk_zero;
    logic [63:0]        seg_rd_data;
    logic [ENTRY_W-1:0] fifo_rd_data;
    logic [ENTRY_W-1:0] fifo_wr_data;
    logic               fifo_wr_en;

    assign head_next = (head_reg == LAST_PTR) ? '0 : head_reg + PW'(1);
    assign tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + PW'(1);
    assign blk_zero  = (blk_bytes_reg == 32'd0);
    assign sum_cnt   = SW'(used_reg) + SW'(cnt_reg);

    // shared multiplier, one product per cycle into the selected register
    always_comb
    begin
        mul_b = blk_bytes_reg;
        unique case (cmd.mul_sel)
            MUL_ROOM: mul_a = MAW'(FD_C) - MAW'(cnt_reg) + MAW'(1);
            MUL_SEG:
            begin
                mul_a = MAW'(segc_reg);
                mul_b = seg_bytes_reg;
            end
            MUL_USED: mul_a = MAW'(used_reg);
            MUL_SUM:  mul_a = MAW'(sum_cnt);
            default:  mul_a = '0;
        endcase
    end

    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    // used + free == floor(total_bytes / block_bytes), checked without dividing
    assign consistent = blk_zero ? (sum_cnt == '0)
                      : ((tot_reg >= sb_reg) && ((tot_reg - sb_reg) < PRW'(blk_bytes_reg)));
    assign below_water = (32'(cnt_reg) < 32'(low_water_reg));

    always_comb
    begin
        sts.segc_zero  = (segc_reg == '0);
        sts.scan_last  = ((SCW'(scan_reg) + SCW'(1)) == segc_reg);
        sts.dup        = dup_reg;
        sts.seg_full   = (segc_reg == SD_C);
        // segment splits into more blocks than the free list has room for
        sts.room_short = !blk_zero && (PRW'(seg_bytes_reg) >= lim_reg);
        sts.push_more  = !blk_zero && (rem_reg >= blk_bytes_reg);
        sts.size_big   = (in_req_reg > blk_bytes_reg);
        sts.fifo_empty = (cnt_reg == '0);
        sts.fifo_full  = (cnt_reg == FD_C);
        sts.out_free   = !out_valid_reg || m_axis_tready;
    end

    assign fifo_wr_en   = cmd.push || cmd.free_push;
    assign fifo_wr_data = cmd.push ? {cur_addr_reg, in_key_reg, in_srv_reg}
                                   : {in_addr_reg, in_key_reg, in_srv_reg};

    uba_ram #(
        .WIDTH (64),
        .DEPTH (SEG_DEPTH),
        .AW    (SIW)
    ) u_seg_ram (
        .clk     (clk),
        .wr_en   (cmd.add_commit),
        .wr_addr (segc_reg[SIW-1:0]),
        .wr_data (in_addr_reg),
        .rd_en   (cmd.scan_rd),
        .rd_addr (scan_reg),
        .rd_data (seg_rd_data)
    );

    uba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FREE_DEPTH),
        .AW    (PW)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (fifo_wr_en),
        .wr_addr (tail_reg),
        .wr_data (fifo_wr_data),
        .rd_en   (cmd.alloc_pop),
        .rd_addr (head_reg),
        .rd_data (fifo_rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_bytes_reg <= SEG_BYTES_RST;
            blk_bytes_reg <= BLK_BYTES_RST;
            low_water_reg <= LOW_WATER_RST;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            used_reg      <= '0;
            segc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SEG_BYTES: seg_bytes_reg <= cfg_data;
                    CFG_BLK_BYTES: blk_bytes_reg <= cfg_data;
                    CFG_LOW_WATER: low_water_reg <= cfg_data[10:0];
                    default:       low_water_reg <= low_water_reg;
                endcase
            end
            if (cmd.add_commit)
            begin
                segc_reg <= segc_reg + SCW'(1);
            end
            if (fifo_wr_en)
            begin
                tail_reg <= tail_next;
                cnt_reg  <= cnt_reg + CW'(1);
                if (cmd.free_push && (used_reg != '0))
                begin
                    used_reg <= used_reg - UW'(1);
                end
            end
            if (cmd.alloc_pop)
            begin
                head_reg <= head_next;
                cnt_reg  <= cnt_reg - CW'(1);
                used_reg <= used_reg + UW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and per-item registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            in_func_reg  <= func_t'(s_axis_tuser);
            in_addr_reg  <= s_axis_tdata[63:0];
            in_key_reg   <= s_axis_tdata[95:64];
            in_srv_reg   <= s_axis_tdata[111:96];
            in_req_reg   <= s_axis_tdata[143:112];
            scan_reg     <= '0;
            dup_reg      <= 1'b0;
            stat_reg     <= ST_OK;
            blk_addr_reg <= '0;
            blk_key_reg  <= '0;
            blk_srv_reg  <= '0;
            blk_size_reg <= '0;
        end
        if (cmd.scan_cmp)
        begin
            if ((seg_rd_data == in_addr_reg) && (in_func_reg == FN_ADD))
            begin
                dup_reg <= 1'b1;
            end
            scan_reg <= scan_reg + SIW'(1);
        end
        if (cmd.set_status)
        begin
            stat_reg <= cmd.code;
        end
        if (cmd.add_commit)
        begin
            cur_addr_reg <= in_addr_reg;
            rem_reg      <= seg_bytes_reg;
        end
        if (cmd.push)
        begin
            cur_addr_reg <= cur_addr_reg + 64'(blk_bytes_reg);
            rem_reg      <= rem_reg - blk_bytes_reg;
        end
        if (cmd.alloc_cap)
        begin
            blk_addr_reg <= fifo_rd_data[111:48];
            blk_key_reg  <= fifo_rd_data[47:16];
            blk_srv_reg  <= fifo_rd_data[15:0];
            blk_size_reg <= blk_bytes_reg;
        end
        if (cmd.ld_lim)
        begin
            lim_reg <= mul_p;
        end
        if (cmd.ld_tot)
        begin
            tot_reg <= mul_p;
        end
        if (cmd.ld_ub)
        begin
            ub_reg <= mul_p;
        end
        if (cmd.ld_sb)
        begin
            sb_reg <= mul_p;
            fb_reg <= 64'(tot_reg) - 64'(ub_reg);
        end
        if (cmd.load_out)
        begin
            out_stat_reg <= stat_reg;
            out_data_reg <= {3'b000, consistent, below_water, 11'(cnt_reg), fb_reg,
                             blk_size_reg, blk_srv_reg, blk_key_reg, blk_addr_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_stat_reg;

endmodule
